[sv/uimt_pkg.sv]
// uimt_pkg: shared types and constants for the USB ID match table.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package uimt_pkg;

  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int MODULE_COUNT_DEF = 64;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 6;
  localparam int MOD_W      = 6;
  localparam int MASK_W     = 10;
  localparam int VP_W       = 32;
  localparam int REL_W      = 16;
  localparam int TRIPLE_W   = 24;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // match_mask bit positions
  localparam int MB_VENDOR   = 0;
  localparam int MB_PRODUCT  = 1;
  localparam int MB_REL_LO   = 2;
  localparam int MB_REL_HI   = 3;
  localparam int MB_DEV_CLS  = 4;
  localparam int MB_DEV_SUB  = 5;
  localparam int MB_DEV_PRO  = 6;
  localparam int MB_INTF_CLS = 7;
  localparam int MB_INTF_SUB = 8;
  localparam int MB_INTF_PRO = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_COUNT  = 2'd0,
    CFG_CHECK_MODE   = 2'd1,
    CFG_CHECK_MODULE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic [VP_W-1:0]     vp;
    logic [REL_W-1:0]    rlo;
    logic [REL_W-1:0]    rhi;
    logic [TRIPLE_W-1:0] dev;
    logic [TRIPLE_W-1:0] intf;
    logic [MOD_W-1:0]    mod_num;
  } entry_t;

  typedef struct packed {
    logic [VP_W-1:0]     vp;
    logic [REL_W-1:0]    bcd;
    logic [TRIPLE_W-1:0] dev;
    logic [TRIPLE_W-1:0] intf;
  } query_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             check_mode;
    logic [MOD_W-1:0] check_module;
  } cfg_t;

  typedef struct packed {
    logic [MOD_W-1:0] found_module;
    logic             has_module;
    logic             check_hit;
    logic             last;
  } result_t;

endpackage

[sv/uimt_table.sv]
// uimt_table: match entry memory, one write port, one registered read port.
// Depends on uimt_pkg (entry_t).
`timescale 1ns / 1ps

module uimt_table #(
  parameter int TABLE_DEPTH = uimt_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  uimt_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output uimt_pkg::entry_t rd_data
);
  import uimt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/uimt_match.sv]
// uimt_match: compare unit, tests one table entry against the query.
// Depends on uimt_pkg (entry_t, query_t, mask bit positions).
`timescale 1ns / 1ps

module uimt_match (
  input  uimt_pkg::entry_t ent,
  input  uimt_pkg::query_t qry,
  output logic             hit
);
  import uimt_pkg::*;

  logic vendor_ok, product_ok, rlo_ok, rhi_ok;
  logic dev_ok, intf_ok;

  always_comb begin
    vendor_ok  = !ent.mask[MB_VENDOR]  || (ent.vp[31:16] == qry.vp[31:16]);
    product_ok = !ent.mask[MB_PRODUCT] || (ent.vp[15:0] == qry.vp[15:0]);
    rlo_ok     = !ent.mask[MB_REL_LO]  || (ent.rlo <= qry.bcd);
    rhi_ok     = !ent.mask[MB_REL_HI]  || (ent.rhi >= qry.bcd);
    dev_ok     = (!ent.mask[MB_DEV_CLS] || (ent.dev[23:16] == qry.dev[23:16])) &&
                 (!ent.mask[MB_DEV_SUB] || (ent.dev[15:8]  == qry.dev[15:8]))  &&
                 (!ent.mask[MB_DEV_PRO] || (ent.dev[7:0]   == qry.dev[7:0]));
    intf_ok    = (!ent.mask[MB_INTF_CLS] || (ent.intf[23:16] == qry.intf[23:16])) &&
                 (!ent.mask[MB_INTF_SUB] || (ent.intf[15:8]  == qry.intf[15:8]))  &&
                 (!ent.mask[MB_INTF_PRO] || (ent.intf[7:0]   == qry.intf[7:0]));
    hit = vendor_ok && product_ok && rlo_ok && rhi_ok && dev_ok && intf_ok;
  end

endmodule

[sv/uimt_walk.sv]
// uimt_walk: command sequencer; table writes, query walk, selection marks
// and result register. Depends on uimt_pkg.
`timescale 1ns / 1ps

module uimt_walk #(
  parameter int TABLE_DEPTH  = uimt_pkg::TABLE_DEPTH_DEF,
  parameter int MODULE_COUNT = uimt_pkg::MODULE_COUNT_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uimt_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [uimt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [uimt_pkg::SLOT_W-1:0]     in_slot,
  input  logic [uimt_pkg::MOD_W-1:0]      in_module_number,
  input  logic [uimt_pkg::MASK_W-1:0]     in_match_mask,
  input  logic [uimt_pkg::VP_W-1:0]       in_vendor_product,
  input  logic [uimt_pkg::REL_W-1:0]      in_release_low,
  input  logic [uimt_pkg::REL_W-1:0]      in_release_high,
  input  logic [uimt_pkg::TRIPLE_W-1:0]   in_device_triple,
  input  logic [uimt_pkg::TRIPLE_W-1:0]   in_interface_triple,
  output logic                            tbl_wr_en,
  output logic [AW-1:0]                   tbl_wr_addr,
  output uimt_pkg::entry_t                tbl_wr_data,
  output logic                            tbl_rd_en,
  output logic [AW-1:0]                   tbl_rd_addr,
  input  uimt_pkg::entry_t                tbl_rd_data,
  output uimt_pkg::query_t                qry,
  input  logic                            match_hit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output uimt_pkg::result_t               out_word
);
  import uimt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (IW > CNT_W) ? IW : CNT_W;
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int MW = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

  walk_state_t             state_r, state_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [IW-1:0]           n_r, n_nxt;
  logic                    dv_r, dv_nxt;
  query_t                  qry_r, qry_nxt;
  logic [MODULE_COUNT-1:0] marks_r, marks_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [MOD_W-1:0]        pend_mod_r, pend_mod_nxt;
  logic                    hit_r, hit_nxt;
  result_t                 out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic             out_free, out_push;
  result_t          push_word;
  logic [MOD_W-1:0] ent_mod;
  logic [MW-1:0]    mark_idx;
  logic             new_hit, chk_hit, pause;
  logic [SW-1:0]    slot_ext;
  logic [NW-1:0]    ec_ext, depth_ext;

  assign ent_mod   = tbl_rd_data.mod_num;
  assign mark_idx  = ent_mod[MW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign new_hit   = dv_r && match_hit && !cfg.check_mode && !marks_r[mark_idx];
  assign chk_hit   = dv_r && match_hit && cfg.check_mode && (ent_mod == cfg.check_module);
  // a new module found while another is pending must wait until the output register can take the pending one
  assign pause     = new_hit && pend_valid_r && !out_free;
  assign slot_ext  = SW'(in_slot);
  assign ec_ext    = NW'(cfg.entry_count);
  assign depth_ext = NW'(TABLE_DEPTH);

  assign in_stall    = (state_r != ST_IDLE);
  assign tbl_wr_addr = slot_ext[AW-1:0];
  assign tbl_rd_addr = idx_r[AW-1:0];
  assign qry         = qry_r;
  assign out_valid   = out_valid_r;
  assign out_word    = out_r;

  always_comb begin
    tbl_wr_data.mask    = in_match_mask;
    tbl_wr_data.vp      = in_vendor_product;
    tbl_wr_data.rlo     = in_release_low;
    tbl_wr_data.rhi     = in_release_high;
    tbl_wr_data.dev     = in_device_triple;
    tbl_wr_data.intf    = in_interface_triple;
    tbl_wr_data.mod_num = (32'(in_module_number) < MODULE_COUNT) ? in_module_number
                                                                : MOD_W'(MODULE_COUNT - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      marks_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      dv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      marks_r      <= marks_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      dv_r         <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    qry_r      <= qry_nxt;
    pend_mod_r <= pend_mod_nxt;
    hit_r      <= hit_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    dv_nxt         = dv_r;
    qry_nxt        = qry_r;
    marks_nxt      = marks_r;
    pend_valid_nxt = pend_valid_r;
    pend_mod_nxt   = pend_mod_r;
    hit_nxt        = hit_r;
    tbl_wr_en      = 1'b0;
    tbl_rd_en      = 1'b0;
    out_push       = 1'b0;
    push_word      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_WRITE: begin
              tbl_wr_en = (32'(in_slot) < TABLE_DEPTH);
            end
            CMD_QUERY: begin
              qry_nxt.vp     = in_vendor_product;
              qry_nxt.bcd    = in_release_low;
              qry_nxt.dev    = in_device_triple;
              qry_nxt.intf   = in_interface_triple;
              n_nxt          = IW'((ec_ext < depth_ext) ? ec_ext : depth_ext);
              idx_nxt        = '0;
              dv_nxt         = 1'b0;
              pend_valid_nxt = 1'b0;
              hit_nxt        = 1'b0;
              state_nxt      = ST_WALK;
            end
            CMD_CLEAR: begin
              marks_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // read slot idx while the previous slot is compared
        if (!pause) begin
          if (new_hit) begin
            marks_nxt[mark_idx] = 1'b1;
            pend_valid_nxt      = 1'b1;
            pend_mod_nxt        = ent_mod;
            if (pend_valid_r) begin
              out_push               = 1'b1;
              push_word.found_module = pend_mod_r;
              push_word.has_module   = 1'b1;
            end
          end
          if (chk_hit) begin
            hit_nxt = 1'b1;
          end
          if (idx_r < n_r) begin
            tbl_rd_en = 1'b1;
            idx_nxt   = IW'(idx_r + 1'b1);
            dv_nxt    = 1'b1;
          end else begin
            dv_nxt    = 1'b0;
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_push       = 1'b1;
          push_word.last = 1'b1;
          if (cfg.check_mode) begin
            push_word.check_hit = hit_r;
          end else if (pend_valid_r) begin
            push_word.found_module = pend_mod_r;
            push_word.has_module   = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_nxt       = out_push ? push_word : out_r;
    out_valid_nxt = out_push ? 1'b1 : (out_valid_r && out_stall);
  end

endmodule

[sv/usb_id_match_table_top.sv]
// usb_id_match_table_top: top level of the USB ID match table.
// Depends on uimt_pkg, uimt_table, uimt_match, uimt_walk.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall) carries one command word: write a
//   table entry, run a query, or clear the selection marks. Result channel
//   (out_valid / out_stall) carries the result words of a query; the final
//   word of every query has out_last set.
//   Writes, clears and unknown commands give no word.
//   A query walks slots 0 .. min(entry_count, TABLE_DEPTH)-1 through one
//   compare unit, one slot per cycle behind a registered memory read unless
//   the walk pauses for the output, then a flush state pushes the final
//   word; in_stall is high through the walk and the flush.
//   Results sit in an output register; a new module can be found while the
//   previous one waits, but the walk pauses when a third one is pending
//   and the receiver keeps out_stall high. A stalled word holds steady.
//   Configuration (cfg_we / cfg_index / cfg_wdata) is to be written only while idle; the block does not enforce this.
//   Reset (rst_n low, synchronous) clears the marks, the control state, the
//   configuration and the output valid; the entry memory is not cleared
//   and must be written before any slot below entry_count is walked.

module usb_id_match_table_top #(
  parameter int TABLE_DEPTH  = uimt_pkg::TABLE_DEPTH_DEF,
  parameter int MODULE_COUNT = uimt_pkg::MODULE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uimt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uimt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uimt_pkg::CMD_W-1:0]        in_cmd,
  input  logic [uimt_pkg::SLOT_W-1:0]       in_slot,
  input  logic [uimt_pkg::MOD_W-1:0]        in_module_number,
  input  logic [uimt_pkg::MASK_W-1:0]       in_match_mask,
  input  logic [uimt_pkg::VP_W-1:0]         in_vendor_product,
  input  logic [uimt_pkg::REL_W-1:0]        in_release_low,
  input  logic [uimt_pkg::REL_W-1:0]        in_release_high,
  input  logic [uimt_pkg::TRIPLE_W-1:0]     in_device_triple,
  input  logic [uimt_pkg::TRIPLE_W-1:0]     in_interface_triple,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uimt_pkg::MOD_W-1:0]        out_found_module,
  output logic                              out_has_module,
  output logic                              out_check_hit,
  output logic                              out_last
);
  import uimt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t    cfg_r, cfg_nxt;
  logic    tbl_wr_en, tbl_rd_en;
  logic [AW-1:0] tbl_wr_addr, tbl_rd_addr;
  entry_t  tbl_wr_data, tbl_rd_data;
  query_t  qry;
  logic    match_hit;
  result_t out_word;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENTRY_COUNT:  cfg_nxt.entry_count  = cfg_wdata[CNT_W-1:0];
        CFG_CHECK_MODE:   cfg_nxt.check_mode   = cfg_wdata[0];
        CFG_CHECK_MODULE: cfg_nxt.check_module = cfg_wdata[MOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  uimt_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  uimt_match u_match (
    .ent (tbl_rd_data),
    .qry (qry),
    .hit (match_hit)
  );

  uimt_walk #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MODULE_COUNT (MODULE_COUNT)
  ) u_walk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_slot             (in_slot),
    .in_module_number    (in_module_number),
    .in_match_mask       (in_match_mask),
    .in_vendor_product   (in_vendor_product),
    .in_release_low      (in_release_low),
    .in_release_high     (in_release_high),
    .in_device_triple    (in_device_triple),
    .in_interface_triple (in_interface_triple),
    .tbl_wr_en           (tbl_wr_en),
    .tbl_wr_addr         (tbl_wr_addr),
    .tbl_wr_data         (tbl_wr_data),
    .tbl_rd_en           (tbl_rd_en),
    .tbl_rd_addr         (tbl_rd_addr),
    .tbl_rd_data         (tbl_rd_data),
    .qry                 (qry),
    .match_hit           (match_hit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_word            (out_word)
  );

  assign out_found_module = out_word.found_module;
  assign out_has_module   = out_word.has_module;
  assign out_check_hit    = out_word.check_hit;
  assign out_last         = out_word.last;

endmodule

[sv/uimt_checker.sv]
// uimt_checker: port-level checks on the match table, bound to the top level.
// Depends on uimt_pkg (command codes).
`timescale 1ns / 1ps

module uimt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [uimt_pkg::CMD_W-1:0]   in_cmd,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [uimt_pkg::MOD_W-1:0]   out_found_module,
  input logic                         out_has_module,
  input logic                         out_check_hit,
  input logic                         out_last
);
  import uimt_pkg::*;

  // an accepted query is followed by in_stall high
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_cmd == CMD_QUERY)) |=> in_stall)
    else $error("input accepted right after a query");

  // a word without a module is always the closing word
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_module) |-> out_last)
    else $error("empty result word not marked last");

  a_check_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_check_hit) |-> (out_last && !out_has_module && (out_found_module == '0)))
    else $error("check hit on a listing word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_found_module) && $stable(out_has_module) &&
       $stable(out_check_hit) && $stable(out_last)))
    else $error("stalled result word changed");

endmodule

bind usb_id_match_table_top uimt_checker u_checker (.*);
